>>> design/wavelet_matrix_access_rank_unit_assert.svh
// Assertion macros shared by the wavelet matrix unit.
`ifndef WAVELET_MATRIX_ACCESS_RANK_UNIT_ASSERT_SVH
`define WAVELET_MATRIX_ACCESS_RANK_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WMAR_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define WMAR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/wmar_pkg.sv
`default_nettype none

package wmar_pkg;

    localparam int MAX_SYMBOLS = 4096;
    localparam int LEVELS      = 4;
    localparam int WORD_BITS   = 64;
    localparam int STORE_WORDS = (MAX_SYMBOLS * LEVELS) / WORD_BITS;

    localparam int ADDR_W   = $clog2(STORE_WORDS);
    localparam int OFF_W    = $clog2(WORD_BITS);
    localparam int CNT_W    = $clog2(WORD_BITS + 1);
    localparam int PREFIX_W = 15;
    localparam int RANK_W   = PREFIX_W + 1;
    localparam int LIX_W    = $clog2(LEVELS);
    localparam int LVL_W    = $clog2(LEVELS + 1);
    localparam int POS_W    = 13;
    localparam int SYM_W    = 4;
    localparam int CALC_W   = 32;

    localparam int OP_W       = 2;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_ACCESS = 2'd1;
    localparam logic [OP_W-1:0] OP_RANK   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZEROS_L0     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZEROS_L3     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OBL_L1       = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OBL_L3       = 4'd7;

    // Input tdata layout, lowest field last.
    typedef struct packed {
        logic [6:0]           pad;
        logic [SYM_W-1:0]     symbol;
        logic [POS_W-1:0]     position;
        logic [63:0]          word_data;
        logic [7:0]           word_index;
    } t_in_data;

    // One rank1 lookup: ones below the index, and the bit at the index.
    typedef struct packed {
        logic [RANK_W-1:0] ones;
        logic              bit_val;
    } t_rank1;

    function automatic logic [CNT_W-1:0] popcount(input logic [WORD_BITS-1:0] w);
        logic [3:0]       byte_cnt [WORD_BITS/8];
        logic [CNT_W-1:0] sum;
        for (int i = 0; i < WORD_BITS / 8; i++) begin
            byte_cnt[i] = '0;
            for (int j = 0; j < 8; j++) begin
                byte_cnt[i] = byte_cnt[i] + 4'(w[8*i+j]);
            end
        end
        sum = '0;
        for (int i = 0; i < WORD_BITS / 8; i++) begin
            sum = sum + CNT_W'(byte_cnt[i]);
        end
        return sum;
    endfunction

endpackage

`default_nettype wire

>>> design/wmar_ram.sv
`default_nettype none

module wmar_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

>>> design/wmar_rank1.sv
`default_nettype none

module wmar_rank1 (
    input  logic [wmar_pkg::WORD_BITS-1:0] i_word,
    input  logic [wmar_pkg::PREFIX_W-1:0]  i_prefix,
    input  logic [wmar_pkg::OFF_W-1:0]     i_off,
    input  logic                           i_full,
    output wmar_pkg::t_rank1               o_res
);
    import wmar_pkg::*;

    logic [WORD_BITS-1:0] w_mask;

    // Count every bit of the word when the index lies past the store.
    assign w_mask = i_full ? '1 : ((WORD_BITS'(1) << i_off) - WORD_BITS'(1));

    assign o_res.ones    = RANK_W'(i_prefix) + RANK_W'(popcount(i_word & w_mask));
    assign o_res.bit_val = !i_full && i_word[i_off];

endmodule

`default_nettype wire

>>> design/wavelet_matrix_access_rank_unit.sv
// Channel   Dir  Handshake                    Payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tuser: op; tdata: index, word, position, symbol
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tuser: range_error; tdata: answer
// cfg       in   i_cfg_valid/o_cfg_ready          i_cfg_index, i_cfg_data
//
// Access walks all four levels; rank walks k (0..4) levels, stopping once the count hits
// zero; a load writes its prefix entry, and out-of-range and unused ops go straight to the result.
// Each level walks three states: a synchronous read of the bit store and prefix RAM,
// a mask-and-popcount, and an update of the position.
// The next item is taken when the walk is over, while the last result may still wait.
// Reset is synchronous, active low; both RAMs are undefined until loaded.
`default_nettype none

`include "wavelet_matrix_access_rank_unit_assert.svh"

module wavelet_matrix_access_rank_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [7:0] word_index, [71:8] word_data, [84:72] position, [88:85] symbol, rest zero
    input  logic [wmar_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // [1:0] op
    input  logic [wmar_pkg::OP_W-1:0]        i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [12:0] answer, rest zero
    output logic [wmar_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // [0] range_error
    output logic                             o_m_axis_tuser,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [wmar_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [wmar_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import wmar_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOAD = 6'b000010,
        S_RD   = 6'b000100,
        S_CNT  = 6'b001000,
        S_UPD  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    // Configuration registers
    logic [POS_W-1:0]    r_sym_count;
    logic [POS_W-1:0]    r_zeros [LEVELS];
    logic [PREFIX_W-1:0] r_obl   [LEVELS];

    // Control
    t_state r_state, n_state;
    logic   r_o_valid;

    // Item and walk state
    logic [OP_W-1:0]     r_op;
    logic [ADDR_W-1:0]   r_widx;
    logic                r_load_ok;
    logic [SYM_W-1:0]    r_sym;
    logic [LVL_W-1:0]    r_lvl;
    logic                r_first;
    logic [CALC_W-1:0]   r_start, r_end, r_len;
    logic [CALC_W-1:0]   r_lvl_base, r_next_base;
    logic                r_oob_a, r_oob_b;
    logic [OFF_W-1:0]    r_off_a, r_off_b;
    logic [RANK_W-1:0]   r_ra, r_rb;
    logic                r_br;
    logic [CALC_W-1:0]   r_d, r_ones, r_e, r_opos, r_t;
    logic [LEVELS-1:0]   r_acc;
    logic [POS_W-1:0]    r_ans;
    logic                r_err;
    logic [POS_W-1:0]    r_o_ans;
    logic                r_o_err;

    t_in_data            w_in;
    logic                w_in_fire, w_cfg_fire, w_out_free;
    logic [LIX_W-1:0]    w_lix;
    logic [CALC_W-1:0]   w_obl, w_zeros;
    logic                w_symbit;
    logic [CALC_W-1:0]   n_start, n_end, n_len;
    logic [CALC_W-1:0]   w_start, w_end, w_len;
    logic                w_oob_a, w_oob_b, w_done;
    logic [ADDR_W-1:0]   w_addr_a, w_addr_b, w_raddr_a;
    logic [WORD_BITS-1:0] w_word_a, w_word_b;
    logic [PREFIX_W-1:0] w_pref_a, w_pref_b;
    t_rank1              w_r1a, w_r1b;
    logic                w_store_we, w_pref_we;
    logic [PREFIX_W-1:0] w_pref_wdata;
    logic                w_acc_err, w_rank_err, w_in_ok;
    logic                w_rank_cnt;

    assign w_in       = t_in_data'(i_s_axis_tdata);
    assign w_in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_cfg_fire = i_cfg_valid && o_cfg_ready;
    assign w_out_free = !r_o_valid || i_m_axis_tready;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'(r_o_ans);
    assign o_m_axis_tuser  = r_o_err;

    // Range checks on the incoming position
    assign w_acc_err  = (w_in.position >= r_sym_count);
    assign w_rank_err = (w_in.position > r_sym_count);
    assign w_in_ok    = ((i_s_axis_tuser == OP_ACCESS) && !w_acc_err) ||
                        ((i_s_axis_tuser == OP_RANK) && !w_rank_err);

    // Per-level constants; the one count before level 0 stays zero.
    assign w_lix    = r_lvl[LIX_W-1:0];
    assign w_obl    = CALC_W'(r_obl[w_lix]);
    assign w_zeros  = CALC_W'(r_zeros[w_lix]);
    assign w_symbit = r_sym[LIX_W'(LEVELS - 1) - w_lix];

    // Next position from the previous level's update terms.
    assign n_start = r_br ? (r_t + r_ones) : (r_t - r_ones);
    assign n_end   = r_t + r_e;
    assign n_len   = r_br ? r_opos : (r_len - r_opos);
    assign w_start = r_first ? r_start : n_start;
    assign w_end   = r_first ? r_end : n_end;
    assign w_len   = r_first ? r_len : n_len;

    assign w_done = (r_lvl == LVL_W'(LEVELS)) || ((r_op == OP_RANK) && (w_len == '0));

    // An index past the store reads the last word with every bit counted.
    assign w_oob_a  = (w_start >> OFF_W) >= CALC_W'(STORE_WORDS);
    assign w_oob_b  = (w_end >> OFF_W) >= CALC_W'(STORE_WORDS);
    assign w_addr_a = w_oob_a ? ADDR_W'(STORE_WORDS - 1) : w_start[OFF_W +: ADDR_W];
    assign w_addr_b = w_oob_b ? ADDR_W'(STORE_WORDS - 1) : w_end[OFF_W +: ADDR_W];

    // While idle, port A fetches the word below a load's index.
    assign w_raddr_a = (r_state == S_IDLE) ? (ADDR_W'(w_in.word_index) - ADDR_W'(1)) : w_addr_a;

    assign w_store_we   = w_in_fire && (i_s_axis_tuser == OP_LOAD) &&
                          (CALC_W'(w_in.word_index) < CALC_W'(STORE_WORDS));
    assign w_pref_we    = (r_state == S_LOAD) && r_load_ok;
    assign w_pref_wdata = (r_widx == '0) ? '0 : w_r1a.ones[PREFIX_W-1:0];

    assign w_rank_cnt = (r_state == S_CNT) && (r_op == OP_RANK);

    wmar_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STORE_WORDS)
    ) u_bit_store (
        .i_clk     (i_clk),
        .i_we      (w_store_we),
        .i_waddr   (ADDR_W'(w_in.word_index)),
        .i_wdata   (w_in.word_data[WORD_BITS-1:0]),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_addr_b),
        .o_rdata_a (w_word_a),
        .o_rdata_b (w_word_b)
    );

    wmar_ram #(
        .WIDTH (PREFIX_W),
        .DEPTH (STORE_WORDS)
    ) u_prefix (
        .i_clk     (i_clk),
        .i_we      (w_pref_we),
        .i_waddr   (r_widx),
        .i_wdata   (w_pref_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_addr_b),
        .o_rdata_a (w_pref_a),
        .o_rdata_b (w_pref_b)
    );

    wmar_rank1 u_rank_a (
        .i_word   (w_word_a),
        .i_prefix (w_pref_a),
        .i_off    (r_off_a),
        .i_full   (r_oob_a),
        .o_res    (w_r1a)
    );

    wmar_rank1 u_rank_b (
        .i_word   (w_word_b),
        .i_prefix (w_pref_b),
        .i_off    (r_off_b),
        .i_full   (r_oob_b),
        .o_res    (w_r1b)
    );

    // Configuration writes; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_count <= '0;
            for (int i = 0; i < LEVELS; i++) begin
                r_zeros[i] <= '0;
                r_obl[i]   <= '0;
            end
        end else if (w_cfg_fire) begin
            if (i_cfg_index == CFG_SYMBOL_COUNT) begin
                r_sym_count <= i_cfg_data[POS_W-1:0];
            end else if (i_cfg_index inside {[CFG_ZEROS_L0:CFG_ZEROS_L3]}) begin
                r_zeros[LIX_W'(i_cfg_index - CFG_ZEROS_L0)] <= i_cfg_data[POS_W-1:0];
            end else if (i_cfg_index inside {[CFG_OBL_L1:CFG_OBL_L3]}) begin
                r_obl[LIX_W'(i_cfg_index - CFG_OBL_L1) + LIX_W'(1)] <= i_cfg_data[PREFIX_W-1:0];
            end
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    if (i_s_axis_tuser == OP_LOAD) begin
                        n_state = S_LOAD;
                    end else if (w_in_ok) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_LOAD: n_state = S_FIN;
            S_RD:   n_state = w_done ? S_FIN : S_CNT;
            S_CNT:  n_state = S_UPD;
            S_UPD:  n_state = S_RD;
            S_FIN:  n_state = w_out_free ? S_IDLE : S_FIN;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_FIN) && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_op        <= i_s_axis_tuser;
                r_widx      <= ADDR_W'(w_in.word_index);
                r_load_ok   <= CALC_W'(w_in.word_index) < CALC_W'(STORE_WORDS);
                r_sym       <= w_in.symbol;
                r_lvl       <= '0;
                r_first     <= 1'b1;
                r_start     <= (i_s_axis_tuser == OP_ACCESS) ? CALC_W'(w_in.position) : '0;
                r_end       <= CALC_W'(w_in.position);
                r_len       <= CALC_W'(w_in.position);
                r_lvl_base  <= '0;
                r_next_base <= CALC_W'(r_sym_count);
                r_acc       <= '0;
                r_oob_a     <= 1'b1;
                r_ans       <= '0;
                r_err       <= ((i_s_axis_tuser == OP_ACCESS) && w_acc_err) ||
                               ((i_s_axis_tuser == OP_RANK) && w_rank_err);
            end
            S_LOAD: begin
                r_ans <= '0;
                r_err <= 1'b0;
            end
            S_RD: begin
                // Commit the new position and issue both reads.
                r_start <= w_start;
                r_end   <= w_end;
                r_len   <= w_len;
                r_oob_a <= w_oob_a;
                r_oob_b <= w_oob_b;
                r_off_a <= w_start[OFF_W-1:0];
                r_off_b <= w_end[OFF_W-1:0];
                r_ans   <= (r_op == OP_RANK) ? w_len[POS_W-1:0] : POS_W'(r_acc);
            end
            S_CNT: begin
                r_ra <= w_r1a.ones;
                r_rb <= w_r1b.ones;
                r_br <= (r_op == OP_ACCESS) ? w_r1a.bit_val : w_symbit;
                r_d  <= r_start - r_lvl_base;
            end
            S_UPD: begin
                r_ones      <= CALC_W'(r_ra) - w_obl;
                r_e         <= r_br ? (CALC_W'(r_rb) - w_obl)
                                    : (r_len + w_obl - CALC_W'(r_rb));
                r_opos      <= CALC_W'(r_rb) - CALC_W'(r_ra);
                r_t         <= r_next_base + (r_br ? w_zeros : r_d);
                r_acc       <= (r_acc << 1) | LEVELS'(r_br);
                r_lvl_base  <= r_next_base;
                r_next_base <= r_next_base + CALC_W'(r_sym_count);
                r_lvl       <= r_lvl + LVL_W'(1);
                r_first     <= 1'b0;
            end
            S_FIN: begin
                if (w_out_free) begin
                    r_o_ans <= r_ans;
                    r_o_err <= r_err;
                end
            end
            default: begin
                r_ans <= '0;
            end
        endcase
    end

    // A transfer in always moves the sequencer out of idle.
    `WMAR_ASSERT_NEXT(a_busy_after_in, w_in_fire, !o_s_axis_tready, "idle after input transfer")
    // Rank keeps the end index equal to start plus remaining length.
    `WMAR_ASSERT_IMPL(a_rank_end, w_rank_cnt, r_end == r_start + r_len, "rank end index drifted")
    // A range error always carries a zero answer.
    `WMAR_ASSERT_IMPL(a_err_zero, r_o_valid && r_o_err, r_o_ans == '0, "error with nonzero answer")

endmodule

`default_nettype wire

>>> tb/tb_wavelet_matrix_access_rank_unit.sv
`timescale 1ns / 100ps

module tb_wavelet_matrix_access_rank_unit;
    import wmar_pkg::*;

    // Op code the block leaves unused; it must answer zero without side effects.
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam int NUM_REGS      = CFG_OBL_L3 + 1;
    localparam int POS_MAX       = (1 << POS_W) - 1;
    localparam int COUNT13_MAX   = (1 << 13) - 1;
    localparam int COUNT15_MAX   = (1 << PREFIX_W) - 1;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 24;
    localparam int LIMIT_CYCLES  = 600000;
    localparam int PHASE_ITEMS   = 450;

    typedef struct packed {
        logic [POS_W-1:0] answer;
        logic             range_error;
    } t_reply;

    // Tracks the matrix contents and register file as the block sees them, and
    // holds the replies still owed by the block, oldest first.
    class wm_scoreboard;
        logic [WORD_BITS-1:0] words [STORE_WORDS];
        logic [PREFIX_W-1:0]  ones_before_word [STORE_WORDS];
        bit [31:0]            n_syms;
        bit [31:0]            zero_cnt [LEVELS];
        bit [31:0]            ones_below [LEVELS];
        t_reply               awaited [$];
        int                   errors;

        function new();
            n_syms = 0;
            errors = 0;
            for (int l = 0; l < LEVELS; l++) begin
                zero_cnt[l]   = 0;
                ones_below[l] = 0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_SYMBOL_COUNT) begin
                n_syms = 32'(data[12:0]);
            end else if (idx >= CFG_ZEROS_L0 && idx <= CFG_ZEROS_L3) begin
                zero_cnt[idx - CFG_ZEROS_L0] = 32'(data[12:0]);
            end else if (idx >= CFG_OBL_L1 && idx <= CFG_OBL_L3) begin
                ones_below[idx - CFG_OBL_L1 + 1] = 32'(data[PREFIX_W-1:0]);
            end
        endfunction

        // Bits past the end of the store read as zero.
        function bit bit_at(bit [31:0] idx);
            bit [31:0] w;
            w = idx >> OFF_W;
            if (w >= STORE_WORDS) return 1'b0;
            return words[w][idx[OFF_W-1:0]];
        endfunction

        // Ones strictly below idx; past the store this is the whole store's total.
        function bit [31:0] rank_ones(bit [31:0] idx);
            bit [31:0]        w;
            logic [OFF_W-1:0] off;
            w   = idx >> OFF_W;
            off = idx[OFF_W-1:0];
            if (w >= STORE_WORDS) begin
                return ones_before_word[STORE_WORDS-1] + $countones(words[STORE_WORDS-1]);
            end
            return ones_before_word[w] +
                   $countones(words[w] & ((64'd1 << off) - 64'd1));
        endfunction

        // Walk down the levels, collecting one symbol bit per level, MSB first.
        function logic [POS_W-1:0] access_symbol(bit [31:0] pos);
            bit [31:0] sym_bits;
            bit [31:0] ones;
            bit [31:0] lv;
            bit        b;
            sym_bits = 0;
            b = bit_at(pos);
            for (lv = 0; lv < LEVELS; lv++) begin
                ones = rank_ones(pos) - ones_below[lv];
                sym_bits = sym_bits << 1;
                if (b) begin
                    sym_bits = sym_bits | 1;
                    pos = (lv + 1) * n_syms + zero_cnt[lv] + ones;
                end else begin
                    pos = (lv + 1) * n_syms + ((pos - lv * n_syms) - ones);
                end
                if (lv + 1 < LEVELS) b = bit_at(pos);
            end
            return sym_bits[POS_W-1:0];
        endfunction

        // Narrow the [start, start+pos) window level by level; stop once it is empty.
        function logic [POS_W-1:0] count_symbol(bit [31:0] pos, logic [SYM_W-1:0] sym);
            bit [31:0]        start;
            bit [31:0]        ones_start;
            bit [31:0]        hits;
            bit [31:0]        ones_in;
            bit [31:0]        lv;
            logic [SYM_W-1:0] pick;
            start = 0;
            pick  = SYM_W'(1 << (LEVELS - 1));
            for (lv = 0; lv < LEVELS && pos != 0; lv++) begin
                ones_start = rank_ones(start);
                hits       = rank_ones(start + pos) - ones_start;
                ones_in    = ones_start - ones_below[lv];
                if ((sym & pick) != 0) begin
                    pos   = hits;
                    start = (lv + 1) * n_syms + zero_cnt[lv] + ones_in;
                end else begin
                    pos   = pos - hits;
                    start = (lv + 1) * n_syms + (start - lv * n_syms - ones_in);
                end
                pick = pick >> 1;
            end
            return pos[POS_W-1:0];
        endfunction

        function void note_input(logic [OP_W-1:0] op, t_in_data d);
            t_reply      r;
            int unsigned w;
            r.answer      = '0;
            r.range_error = 1'b0;
            case (op)
                OP_LOAD: begin
                    w = d.word_index;
                    words[w] = d.word_data;
                    if (w == 0) begin
                        ones_before_word[0] = '0;
                    end else begin
                        ones_before_word[w] = PREFIX_W'(ones_before_word[w-1] +
                                                        $countones(words[w-1]));
                    end
                end
                OP_ACCESS: begin
                    if (32'(d.position) >= n_syms) r.range_error = 1'b1;
                    else r.answer = access_symbol(32'(d.position));
                end
                OP_RANK: begin
                    if (32'(d.position) > n_syms) r.range_error = 1'b1;
                    else r.answer = count_symbol(32'(d.position), d.symbol);
                end
                default: ;
            endcase
            awaited.push_back(r);
        endfunction

        function void check_result(logic [POS_W-1:0] answer, logic range_error);
            t_reply r;
            if (awaited.size() == 0) begin
                $display("%0t: result with nothing outstanding: answer=%0d range_error=%0b",
                         $time, answer, range_error);
                errors++;
                return;
            end
            r = awaited.pop_front();
            if (answer !== r.answer) begin
                $display("%0t: answer mismatch: expected %0d, got %0d",
                         $time, r.answer, answer);
                errors++;
            end
            if (range_error !== r.range_error) begin
                $display("%0t: range_error mismatch: expected %0b, got %0b",
                         $time, r.range_error, range_error);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata  = '0;
    logic [OP_W-1:0]       i_s_axis_tuser  = OP_LOAD;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tuser;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;

    wm_scoreboard sb = new();

    // Register image and store image for the next matrix to be programmed.
    logic [CFG_DATA_W-1:0] reg_vals [NUM_REGS];
    logic [WORD_BITS-1:0]  level_words [STORE_WORDS];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_orders    = 0;
    int hold_served    = 0;
    int stall_left     = 0;
    int items_sent     = 0;
    int cycle_count    = 0;

    wavelet_matrix_access_rank_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Bound the run; a hang anywhere ends up here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off whenever one is ordered.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left      <= stall_left - 1;
        end else if (hold_served != hold_orders) begin
            i_m_axis_tready <= 1'b0;
            hold_served     <= hold_served + 1;
            stall_left      <= HOLD_CYCLES;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Observe every transfer. Check results before noting new inputs so the
    // order within one edge is fixed.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_result(o_m_axis_tdata[POS_W-1:0], o_m_axis_tuser);
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.note_input(i_s_axis_tuser, t_in_data'(i_s_axis_tdata));
        end
    end

    // Offer one item and hold it until the transfer. Keep tvalid high when the
    // next item follows at once; otherwise drop it for a random gap.
    task automatic send_item(logic [OP_W-1:0] op, logic [7:0] widx, logic [63:0] wdata,
                             logic [POS_W-1:0] pos, logic [SYM_W-1:0] sym);
        t_in_data d;
        int       gap;
        d.pad        = '0;
        d.symbol     = sym;
        d.position   = pos;
        d.word_data  = wdata;
        d.word_index = widx;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= d;
        do @(posedge i_clk); while (!o_s_axis_tready);
        items_sent++;
        if ($urandom_range(99) < src_idle_pct) begin
            gap = $urandom_range(16, 1);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Query with junk in the load-only fields; the block must ignore them.
    task automatic query(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, logic [SYM_W-1:0] sym);
        send_item(op, 8'($urandom), {$urandom, $urandom}, pos, sym);
    endtask

    // Drop the offer, wait until every owed result is in, then let the block go quiet.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all registers back to back from reg_vals; call only when idle.
    task automatic program_regs();
        for (int i = 0; i < NUM_REGS; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(i);
            i_cfg_data  <= reg_vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_wild_regs();
        for (int i = 0; i < NUM_REGS; i++) begin
            if (i >= CFG_OBL_L1) reg_vals[i] = CFG_DATA_W'($urandom_range(COUNT15_MAX));
            else reg_vals[i] = CFG_DATA_W'($urandom_range(COUNT13_MAX));
        end
    endtask

    // Build a consistent matrix over a random sequence of n symbols, program
    // its counts and load its words in ascending order.
    task automatic load_matrix(int n);
        logic [SYM_W-1:0] seq [$];
        logic [SYM_W-1:0] zero_side [$];
        logic [SYM_W-1:0] one_side [$];
        logic [SYM_W-1:0] keep;
        logic             b;
        int               zeros;
        int               ones_acc;
        int               gidx;
        int               nwords;
        nwords = (LEVELS * n + WORD_BITS - 1) / WORD_BITS;
        // Narrow alphabets leave symbols absent, so rank walks end early.
        keep = ($urandom_range(2) == 0) ? SYM_W'($urandom) : '1;
        for (int i = 0; i < n; i++) seq.push_back(SYM_W'($urandom) & keep);
        for (int w = 0; w < nwords; w++) level_words[w] = '0;
        ones_acc = 0;
        for (int lv = 0; lv < LEVELS; lv++) begin
            zeros = 0;
            zero_side.delete();
            one_side.delete();
            for (int i = 0; i < n; i++) begin
                b    = seq[i][SYM_W-1-lv];
                gidx = lv * n + i;
                level_words[gidx / WORD_BITS][gidx % WORD_BITS] = b;
                if (b) begin
                    one_side.push_back(seq[i]);
                end else begin
                    zero_side.push_back(seq[i]);
                    zeros++;
                end
            end
            reg_vals[CFG_ZEROS_L0 + lv] = CFG_DATA_W'(zeros);
            if (lv > 0) reg_vals[CFG_OBL_L1 + lv - 1] = CFG_DATA_W'(ones_acc);
            ones_acc += n - zeros;
            // Stable partition: zeros first, then ones, as the next level sees them.
            seq = {zero_side, one_side};
        end
        reg_vals[CFG_SYMBOL_COUNT] = CFG_DATA_W'(n);
        drain();
        program_regs();
        for (int w = 0; w < nwords; w++)
            send_item(OP_LOAD, 8'(w), level_words[w], POS_W'($urandom), SYM_W'($urandom));
    endtask

    // Mostly in-range access and rank, some out of range, a little noise.
    task automatic run_queries(int n, bit wild, int count);
        int               pick;
        logic [POS_W-1:0] pos;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick < 3) begin
                send_item(OP_LOAD, 8'($urandom), {$urandom, $urandom},
                          POS_W'($urandom), SYM_W'($urandom));
            end else if (pick < 7) begin
                query(OP_SPARE, POS_W'($urandom), SYM_W'($urandom));
            end else if (pick < 53) begin
                if (wild) pos = POS_W'($urandom);
                else if (n == 0 || pick < 12) pos = POS_W'($urandom_range(POS_MAX, n));
                else pos = POS_W'($urandom_range(n - 1, 0));
                query(OP_ACCESS, pos, SYM_W'($urandom));
            end else begin
                if (wild) pos = POS_W'($urandom);
                else if (pick > 94) pos = POS_W'($urandom_range(POS_MAX, n + 1));
                else pos = POS_W'($urandom_range(n, 0));
                query(OP_RANK, pos, SYM_W'($urandom));
            end
        end
    endtask

    initial begin
        int phase_start;
        int n;
        int pick;

        src_idle_pct = 16;
        sink_stall_pct <= 53;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty sequence straight out of reset: nothing touches the store.
        query(OP_SPARE, '1, '1);
        query(OP_ACCESS, '0, '0);
        query(OP_RANK, '0, 4'd9);
        query(OP_RANK, POS_W'(1), 4'd9);

        // Largest matrix fills the whole store, so no word is left unwritten.
        load_matrix(MAX_SYMBOLS);
        query(OP_ACCESS, '0, '0);
        query(OP_ACCESS, POS_W'(MAX_SYMBOLS - 1), '0);
        query(OP_ACCESS, POS_W'(MAX_SYMBOLS), '0);
        query(OP_ACCESS, POS_W'(POS_MAX), '0);
        // Full-length rank of the all-ones symbol ends past the store.
        query(OP_RANK, POS_W'(MAX_SYMBOLS), '1);
        query(OP_RANK, POS_W'(MAX_SYMBOLS), '0);
        query(OP_RANK, '0, 4'd7);
        query(OP_RANK, POS_W'(MAX_SYMBOLS / 2), 4'd5);
        query(OP_RANK, POS_W'(MAX_SYMBOLS + 1), 4'd3);
        query(OP_RANK, POS_W'(POS_MAX), '1);
        send_item(OP_SPARE, '1, '1, '1, '1);

        // Extreme words at both ends of the store.
        send_item(OP_LOAD, 8'(STORE_WORDS - 1), '1, '0, '0);
        send_item(OP_LOAD, '0, '0, '1, '1);
        query(OP_ACCESS, POS_W'(MAX_SYMBOLS - 1), '0);
        query(OP_RANK, POS_W'(MAX_SYMBOLS), '1);

        // Every register at its field maximum: arithmetic wraps, reads run off the store.
        drain();
        for (int i = 0; i < NUM_REGS; i++)
            reg_vals[i] = CFG_DATA_W'((i >= CFG_OBL_L1) ? COUNT15_MAX : COUNT13_MAX);
        program_regs();
        query(OP_ACCESS, '0, '0);
        query(OP_ACCESS, POS_W'(POS_MAX - 1), '0);
        query(OP_RANK, POS_W'(POS_MAX), '1);
        query(OP_RANK, POS_W'(100), '0);

        // Random part, three idling profiles in turn.
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin src_idle_pct = 16; sink_stall_pct <= 53; end
                1: begin src_idle_pct = 53; sink_stall_pct <= 16; end
                default: begin src_idle_pct = 0; sink_stall_pct <= 0; end
            endcase
            phase_start = items_sent;
            if (ph == 2) begin
                // Stall the result side for a long stretch while items keep
                // coming, so the block backs up into its input.
                load_matrix(64);
                hold_orders <= hold_orders + 1;
                run_queries(64, 1'b0, 40);
                drain();
            end
            while (items_sent - phase_start < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 12) begin
                    drain();
                    set_wild_regs();
                    program_regs();
                    run_queries(0, 1'b1, $urandom_range(40, 15));
                end else begin
                    if (pick < 17) n = 0;
                    else if (pick < 20) n = MAX_SYMBOLS;
                    else n = $urandom_range(160, 1);
                    load_matrix(n);
                    run_queries(n, 1'b0, $urandom_range(60, 20));
                end
            end
        end

        drain();
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
